/* hdl/hidkb_pkg.sv */
// ----------------------------------------------------------------------------
// hidkb_pkg
// Types, constants and lookup functions for the boot keyboard report decoder.
// ----------------------------------------------------------------------------
package hidkb_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int IN_BYTES  = 8;
  localparam int OUT_BYTES = 3;

  localparam logic [7:0] KEY_CAPS   = 8'h39;
  localparam logic [7:0] MOD_SHIFT  = 8'h22;
  localparam logic [7:0] MOD_CTRL   = 8'h11;
  localparam logic [7:0] MOD_ALT    = 8'h44;
  localparam logic [7:0] KEY_LETTER_FIRST = 8'h04;
  localparam logic [7:0] KEY_LETTER_LAST  = 8'h1D;

  localparam logic [2:0] PC_WAIT   = 3'd0;
  localparam logic [2:0] PC_COMMIT = 3'd7;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_SLOT,
    OP_COMMIT
  } uop_t;

  typedef struct packed {
    uop_t       op;
    logic [2:0] slot;
    logic [2:0] next_pc;
    logic [2:0] jump_pc;
  } ucode_t;

  // microprogram: wait for a report, walk up to six slots, commit previous keys
  function automatic ucode_t ucode_rom(input logic [2:0] pc);
    ucode_t w;
    begin
      case (pc)
        3'd0:    w = '{op: OP_WAIT,   slot: 3'd0, next_pc: 3'd1, jump_pc: PC_WAIT};
        3'd1:    w = '{op: OP_SLOT,   slot: 3'd0, next_pc: 3'd2, jump_pc: PC_COMMIT};
        3'd2:    w = '{op: OP_SLOT,   slot: 3'd1, next_pc: 3'd3, jump_pc: PC_COMMIT};
        3'd3:    w = '{op: OP_SLOT,   slot: 3'd2, next_pc: 3'd4, jump_pc: PC_COMMIT};
        3'd4:    w = '{op: OP_SLOT,   slot: 3'd3, next_pc: 3'd5, jump_pc: PC_COMMIT};
        3'd5:    w = '{op: OP_SLOT,   slot: 3'd4, next_pc: 3'd6, jump_pc: PC_COMMIT};
        3'd6:    w = '{op: OP_SLOT,   slot: 3'd5, next_pc: PC_COMMIT, jump_pc: PC_COMMIT};
        3'd7:    w = '{op: OP_COMMIT, slot: 3'd0, next_pc: PC_WAIT, jump_pc: PC_WAIT};
        default: w = '{op: OP_WAIT,   slot: 3'd0, next_pc: PC_WAIT, jump_pc: PC_WAIT};
      endcase
      return w;
    end
  endfunction

  // navigation usage to set-1 scan code, 0 if not a navigation key
  function automatic logic [6:0] nav_scan(input logic [7:0] key);
    logic [6:0] s;
    begin
      case (key)
        8'h4F:   s = 7'h4D;
        8'h50:   s = 7'h4B;
        8'h51:   s = 7'h50;
        8'h52:   s = 7'h48;
        8'h4C:   s = 7'h53;
        8'h4A:   s = 7'h47;
        8'h4D:   s = 7'h4F;
        8'h4B:   s = 7'h49;
        8'h4E:   s = 7'h51;
        default: s = 7'h00;
      endcase
      return s;
    end
  endfunction

  // usage to ASCII, plain or shifted
  function automatic logic [6:0] key_ascii(input logic [7:0] key, input logic upper);
    logic [6:0] a;
    logic [7:0] ofs;
    begin
      ofs = key - KEY_LETTER_FIRST;
      if (key >= KEY_LETTER_FIRST && key <= KEY_LETTER_LAST) begin
        a = (upper ? 7'h41 : 7'h61) + ofs[6:0];
      end else begin
        case (key)
          8'h1E:   a = upper ? 7'h21 : 7'h31;
          8'h1F:   a = upper ? 7'h40 : 7'h32;
          8'h20:   a = upper ? 7'h23 : 7'h33;
          8'h21:   a = upper ? 7'h24 : 7'h34;
          8'h22:   a = upper ? 7'h25 : 7'h35;
          8'h23:   a = upper ? 7'h5E : 7'h36;
          8'h24:   a = upper ? 7'h26 : 7'h37;
          8'h25:   a = upper ? 7'h2A : 7'h38;
          8'h26:   a = upper ? 7'h28 : 7'h39;
          8'h27:   a = upper ? 7'h29 : 7'h30;
          8'h28:   a = 7'h0A;
          8'h29:   a = 7'h1B;
          8'h2A:   a = 7'h08;
          8'h2B:   a = 7'h09;
          8'h2C:   a = 7'h20;
          8'h2D:   a = upper ? 7'h5F : 7'h2D;
          8'h2E:   a = upper ? 7'h2B : 7'h3D;
          8'h2F:   a = upper ? 7'h7B : 7'h5B;
          8'h30:   a = upper ? 7'h7D : 7'h5D;
          8'h31:   a = upper ? 7'h7C : 7'h5C;
          8'h33:   a = upper ? 7'h3A : 7'h3B;
          8'h34:   a = upper ? 7'h22 : 7'h27;
          8'h35:   a = upper ? 7'h7E : 7'h60;
          8'h36:   a = upper ? 7'h3C : 7'h2C;
          8'h37:   a = upper ? 7'h3E : 7'h2E;
          8'h38:   a = upper ? 7'h3F : 7'h2F;
          default: a = 7'h00;
        endcase
      end
      return a;
    end
  endfunction

endpackage

/* hdl/hidkb_keymap.sv */
// ----------------------------------------------------------------------------
// hidkb_keymap
// Maps one key usage to a scan code or an ASCII character.
// ----------------------------------------------------------------------------
module hidkb_keymap (
  input  logic [7:0] key,
  input  logic       upper,
  output logic [6:0] scan_code,
  output logic [6:0] ascii_char
);
  import hidkb_pkg::*;

  always_comb begin
    scan_code  = nav_scan(key);
    ascii_char = (scan_code != 7'h00) ? 7'h00 : key_ascii(key, upper);
  end

endmodule

/* hdl/hid_boot_keyboard_report_to_keys.sv */
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_to_keys
// Decodes boot keyboard reports into key press events under a microprogram.
// ----------------------------------------------------------------------------
// An event is registered in the slot step of its own slot, after the slot steps
//   ahead of it; a stalled output holds the slot step.
// Reports are taken only in the wait step; the slot steps run up to the last slot
//   with a new key, then the commit; a report with no key slot skips both.
// Reset: synchronous active-low; clears previous keys, caps lock, step counter
//   and output valid.
module hid_boot_keyboard_report_to_keys #(
  parameter int REPORT_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // modifiers, key_0..key_5, report_length, zero pad
  input  logic [8*hidkb_pkg::IN_BYTES-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // scan_code, ascii_char, shift_held, ctrl_held, alt_held, caps_state, zero pad
  output logic [8*hidkb_pkg::OUT_BYTES-1:0]   out_tdata,
  output logic                                out_tlast
);
  import hidkb_pkg::*;

  logic [2:0]                 pc_r, pc_nxt;
  ucode_t                     uw;
  logic [KEY_SLOTS-1:0][7:0]  prev_r, keys_r;
  logic [KEY_SLOTS-1:0]       on_r, ev_r, cp_r;
  logic [KEY_SLOTS-1:0]       on_in, ev_in, cp_in, rest_ev, rest_any;
  logic                       sh_r, ct_r, al_r, caps_r;
  logic [KEY_SLOTS-1:0][7:0]  keys_in;
  logic [3:0]                 len_in, len_eff;
  logic                       in_fire, out_free, cur_ev, cur_cp, stall;
  logic [6:0]                 scan_w, ascii_w;
  logic                       out_valid_r;
  logic [8*OUT_BYTES-1:0]     out_data_r;
  logic                       out_last_r;

  assign uw        = ucode_rom(pc_r);
  assign in_tready = (uw.op == OP_WAIT);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  always_comb begin
    len_in  = in_tdata[59:56];
    len_eff = (len_in > 4'(REPORT_BYTES)) ? 4'(REPORT_BYTES) : len_in;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      keys_in[s] = in_tdata[8*(s+1) +: 8];
      on_in[s]   = (4'(s + 2) < len_eff);
      ev_in[s]   = on_in[s] && (keys_in[s] != 8'h00);
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_r[j] == keys_in[s]) ev_in[s] = 1'b0;
      end
      cp_in[s] = ev_in[s] && (keys_in[s] == KEY_CAPS);
      ev_in[s] = ev_in[s] && (keys_in[s] != KEY_CAPS);
    end
  end

  always_comb begin
    for (int s = 0; s < KEY_SLOTS; s++) begin
      rest_ev[s]  = 1'b0;
      rest_any[s] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (j > s) begin
          rest_ev[s]  = rest_ev[s] | ev_r[j];
          rest_any[s] = rest_any[s] | ev_r[j] | cp_r[j];
        end
      end
    end
  end

  assign cur_ev = (uw.op == OP_SLOT) && ev_r[uw.slot];
  assign cur_cp = (uw.op == OP_SLOT) && cp_r[uw.slot];
  assign stall  = cur_ev && !out_free;

  hidkb_keymap u_keymap (
    .key        (keys_r[uw.slot]),
    .upper      (sh_r ^ caps_r),
    .scan_code  (scan_w),
    .ascii_char (ascii_w)
  );

  always_comb begin
    pc_nxt = pc_r;
    case (uw.op)
      OP_WAIT: begin
        if (in_fire && on_in[0]) pc_nxt = uw.next_pc;
      end
      OP_SLOT: begin
        if (!stall) pc_nxt = rest_any[uw.slot] ? uw.next_pc : uw.jump_pc;
      end
      OP_COMMIT: pc_nxt = uw.next_pc;
      default:   pc_nxt = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      prev_r      <= '0;
      caps_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cur_cp) caps_r <= ~caps_r;
      if (cur_ev && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (uw.op == OP_COMMIT) begin
        for (int s = 0; s < KEY_SLOTS; s++) begin
          prev_r[s] <= on_r[s] ? keys_r[s] : 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      keys_r <= keys_in;
      on_r   <= on_in;
      ev_r   <= ev_in;
      cp_r   <= cp_in;
      sh_r   <= |(in_tdata[7:0] & MOD_SHIFT);
      ct_r   <= |(in_tdata[7:0] & MOD_CTRL);
      al_r   <= |(in_tdata[7:0] & MOD_ALT);
    end
    if (cur_ev && out_free) begin
      out_data_r <= {6'b0, caps_r, al_r, ct_r, sh_r, ascii_w, scan_w};
      out_last_r <= ~rest_ev[uw.slot];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_out_from_slot: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(uw.op == OP_SLOT))
    else $error("output loaded outside a slot step");

  a_caps_from_slot: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(caps_r) |-> $past(cur_cp))
    else $error("caps lock changed without a caps key");

  a_prev_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(prev_r) |-> $past(uw.op == OP_COMMIT))
    else $error("previous keys changed outside commit");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending event lost");

endmodule
